@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion macros, empty when synthesized
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every rising clock edge outside reset
`define C3F_ASSERT(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) \
    else $error("c3f assertion failed");
// expression must never be true outside reset
`define C3F_ASSERT_NEVER(lbl, ck, rs, expr) \
  lbl: assert property (@(posedge ck) disable iff (rs) !(expr)) \
    else $error("c3f forbidden condition seen");
`else
`define C3F_ASSERT(lbl, ck, rs, prop)
`define C3F_ASSERT_NEVER(lbl, ck, rs, expr)
`endif

`endif

@@ hdl/c3f_pkg.sv @@
// ----------------------------------------------------------------------------
// c3f_pkg
// shared types and constants of the 3x3 convolution filter
// ----------------------------------------------------------------------------
package c3f_pkg;

  localparam int DEF_MAX_WIDTH       = 1024;
  localparam int DEF_COEFF_FRAC_BITS = 12;

  localparam int PIX_W      = 8;
  localparam int COEFF_W    = 16;
  localparam int PROD_W     = 24;
  localparam int ROW_SUM_W  = 26;
  localparam int SUM_W      = 28;
  localparam int ROW_W      = 12;
  localparam int TAPS       = 3;

  localparam int FRAME_WIDTH_W  = 11;
  localparam int FRAME_HEIGHT_W = 13;
  localparam int MAX_HEIGHT     = 4096;
  localparam int MIN_DIM        = 3;
  localparam int FIRST_INTERIOR = 2;
  localparam int PIX_MAX        = 255;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RESET  = 11'd640;
  localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RESET = 13'd480;
  localparam logic [CFG_DATA_W-1:0]     COEFF_ROW_RESET    = 48'h01C7_01C7_01C7;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_COEFF_TOP    = 3'd2,
    REG_COEFF_MID    = 3'd3,
    REG_COEFF_BOTTOM = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

@@ hdl/c3f_ram.sv @@
// ----------------------------------------------------------------------------
// c3f_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module c3f_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hdl/c3f_cell.sv @@
// ----------------------------------------------------------------------------
// c3f_cell
// one window tap: holds a pixel, hands it left, registers pixel times coeff
// ----------------------------------------------------------------------------
module c3f_cell (
  input  logic                                clk,
  input  c3f_pkg::cell_ctrl_t                 ctrl,
  input  logic [c3f_pkg::PIX_W-1:0]           pix_in,
  input  logic signed [c3f_pkg::COEFF_W-1:0]  coeff,
  output logic [c3f_pkg::PIX_W-1:0]           pix,
  output logic signed [c3f_pkg::PROD_W-1:0]   prod
);
  import c3f_pkg::*;

  logic signed [PIX_W:0]    pix_s;
  logic signed [PROD_W-1:0] mul;

  assign pix_s = {1'b0, pix};
  assign mul   = PROD_W'(pix_s) * PROD_W'(coeff);

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      pix <= pix_in;
    end
    if (ctrl.load) begin
      prod <= mul;
    end
  end

endmodule

@@ hdl/conv3x3_image_filter.sv @@
// ----------------------------------------------------------------------------
// conv3x3_image_filter
// streaming 3x3 convolution over a greyscale frame, box filter at reset
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  s_tdata = pixel_in
//  m_*      out  m_tvalid/m_tready  m_tdata = pixel_out, m_tlast = frame_end
//  cfg_*    in   cfg_valid/ready    cfg_index, cfg_data
//
//  one pixel accepted per clock while s_tready is high; the ram is read at
//  the edge that accepts a pixel, then its result passes window shift,
//  multiply in the cells, row sums, total, saturate and the output register
//  synchronous reset, ready at once: the line stores need no clearing pass
//  s_tready drops only while the output register holds an untaken result
//  and another result has reached the last stage
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module conv3x3_image_filter #(
  parameter int MAX_WIDTH       = c3f_pkg::DEF_MAX_WIDTH,
  parameter int COEFF_FRAC_BITS = c3f_pkg::DEF_COEFF_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [c3f_pkg::PIX_W-1:0]         s_tdata,    // 7:0 pixel_in
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [c3f_pkg::PIX_W-1:0]         m_tdata,    // 7:0 pixel_out
  output logic                              m_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [c3f_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [c3f_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import c3f_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);

  logic [FRAME_WIDTH_W-1:0]  frame_width;
  logic [FRAME_HEIGHT_W-1:0] frame_height;
  logic [CFG_DATA_W-1:0]     coeff_rows [TAPS];

  logic [COL_W-1:0] col, last_col;
  logic [ROW_W-1:0] row, last_row;
  logic             geom_wr;

  logic adv, accept;
  logic produce0, last0;

  logic             v1, prod1, last1;
  logic [PIX_W-1:0] px1;
  logic [COL_W-1:0] col1;
  logic             v2, last2, v3, last3, v4, last4, v5, last5;

  logic [PIX_W-1:0] line_a_q, line_b_q;
  logic [PIX_W-1:0] col_in [TAPS];
  logic [PIX_W-1:0] tap [TAPS*TAPS];
  logic signed [PROD_W-1:0] prod [TAPS*TAPS];
  cell_ctrl_t cell_ctrl;

  logic signed [ROW_SUM_W-1:0] rsum [TAPS];
  logic signed [SUM_W-1:0]     total, shifted;
  logic [PIX_W-1:0]            sat;

  logic             out_valid, out_last;
  logic [PIX_W-1:0] out_data;

  // configuration
  assign cfg_ready = 1'b1;
  assign geom_wr   = cfg_valid &&
                     (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
      for (int i = 0; i < TAPS; i++) begin
        coeff_rows[i] <= COEFF_ROW_RESET;
      end
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width   <= cfg_data[FRAME_WIDTH_W-1:0];
        REG_FRAME_HEIGHT: frame_height  <= cfg_data[FRAME_HEIGHT_W-1:0];
        REG_COEFF_TOP:    coeff_rows[0] <= cfg_data;
        REG_COEFF_MID:    coeff_rows[1] <= cfg_data;
        REG_COEFF_BOTTOM: coeff_rows[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (frame_width < FRAME_WIDTH_W'(MIN_DIM)) begin
      last_col = COL_W'(MIN_DIM - 1);
    end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
      last_col = COL_W'(MAX_WIDTH - 1);
    end else begin
      last_col = COL_W'(frame_width - 1'b1);
    end
    if (frame_height < FRAME_HEIGHT_W'(MIN_DIM)) begin
      last_row = ROW_W'(MIN_DIM - 1);
    end else if (frame_height > FRAME_HEIGHT_W'(MAX_HEIGHT)) begin
      last_row = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      last_row = ROW_W'(frame_height - 1'b1);
    end
  end

  // flow control
  assign adv      = !(v5 && out_valid && !m_tready);
  assign s_tready = adv;
  assign accept   = s_tvalid && adv;

  assign produce0 = (row >= ROW_W'(FIRST_INTERIOR)) && (col >= COL_W'(FIRST_INTERIOR));
  assign last0    = (row == last_row) && (col == last_col);

  // raster position
  always_ff @(posedge clk) begin
    if (rst || geom_wr) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (col == last_col) begin
        col <= '0;
        row <= (row == last_row) ? '0 : row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  // pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (adv) begin
      v1 <= accept;
      v2 <= v1 && prod1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px1   <= s_tdata;
      col1  <= col;
      prod1 <= produce0;
      last1 <= last0;
      last2 <= last1;
      last3 <= last2;
      last4 <= last3;
      last5 <= last4;
    end
  end

  // line stores
  c3f_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_a (
    .clk     (clk),
    .wr_en   (v1 && adv),
    .wr_addr (col1),
    .wr_data (px1),
    .rd_en   (accept),
    .rd_addr (col),
    .rd_data (line_a_q)
  );

  c3f_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_b (
    .clk     (clk),
    .wr_en   (v1 && adv),
    .wr_addr (col1),
    .wr_data (line_a_q),
    .rd_en   (accept),
    .rd_addr (col),
    .rd_data (line_b_q)
  );

  // window cells, new column enters on the right
  assign cell_ctrl.shift = v1 && adv;
  assign cell_ctrl.load  = adv;
  assign col_in[0] = line_b_q;
  assign col_in[1] = line_a_q;
  assign col_in[2] = px1;

  for (genvar k = 0; k < TAPS; k++) begin : g_row
    for (genvar z = 0; z < TAPS; z++) begin : g_cell
      logic [PIX_W-1:0] pin;
      if (z == TAPS - 1) begin : g_edge
        assign pin = col_in[k];
      end else begin : g_inner
        assign pin = tap[k*TAPS + z + 1];
      end
      c3f_cell u_cell (
        .clk    (clk),
        .ctrl   (cell_ctrl),
        .pix_in (pin),
        .coeff  ($signed(coeff_rows[k][COEFF_W*z +: COEFF_W])),
        .pix    (tap[k*TAPS + z]),
        .prod   (prod[k*TAPS + z])
      );
    end
  end

  // adder tree
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < TAPS; k++) begin
        rsum[k] <= ROW_SUM_W'(prod[k*TAPS]) + ROW_SUM_W'(prod[k*TAPS + 1])
                 + ROW_SUM_W'(prod[k*TAPS + 2]);
      end
      total <= SUM_W'(rsum[0]) + SUM_W'(rsum[1]) + SUM_W'(rsum[2]);
    end
  end

  // truncate and saturate
  assign shifted = total >>> COEFF_FRAC_BITS;

  always_comb begin
    if (total[SUM_W-1] || total == '0) begin
      sat = '0;
    end else if (shifted > SUM_W'(PIX_MAX)) begin
      sat = PIX_W'(PIX_MAX);
    end else begin
      sat = shifted[PIX_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && v5) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v5) begin
      out_data <= sat;
      out_last <= last5;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tlast  = out_last;

  `C3F_ASSERT_NEVER(col_range_a, clk, rst, col > last_col)
  `C3F_ASSERT_NEVER(row_range_a, clk, rst, row > last_row)
  `C3F_ASSERT(stall_cause_a, clk, rst, !s_tready |-> (m_tvalid && !m_tready))

endmodule

@@ tb/sv/tb_conv3x3_image_filter.sv @@
// ----------------------------------------------------------------------------
// tb_conv3x3_image_filter
// Checks the streaming 3x3 convolution filter against its own predictor. The
// predictor keeps line stores, window and raster position and works out each
// interior result. Frames are small and of random size, with a few at the
// clamped extremes. Kernels range over box, random, saturating and zero.
// Both stream sides stall at random. Results are compared in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_conv3x3_image_filter;
  import c3f_pkg::*;

  localparam int CYCLE_LIMIT   = 600_000;
  localparam int SETTLE_CYCLES = 12;
  localparam int REPORT_LIMIT  = 10;
  localparam int RANDOM_ITEMS  = 1100;

  localparam int REG_UNMAPPED_FIRST = int'(REG_COEFF_BOTTOM) + 1;
  localparam int REG_UNMAPPED_LAST  = (1 << CFG_IDX_W) - 1;

  localparam logic [COEFF_W-1:0] COEFF_MAX_POS = 16'h7FFF;
  localparam logic [COEFF_W-1:0] COEFF_MAX_NEG = 16'h8000;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  typedef struct packed {
    cfg_idx_t              idx;
    logic [CFG_DATA_W-1:0] val;
  } cfg_write_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             last;
  } filtered_px_t;

  typedef enum int {
    KERNEL_BOX,
    KERNEL_SMALL,
    KERNEL_FULL,
    KERNEL_MAX_POS,
    KERNEL_MAX_NEG,
    KERNEL_ZERO
  } kernel_kind_t;

  class filter_scoreboard;
    int unsigned           width_reg;
    int unsigned           height_reg;
    logic [CFG_DATA_W-1:0] coeff_row [TAPS];
    logic [PIX_W-1:0]      row_above [DEF_MAX_WIDTH];
    logic [PIX_W-1:0]      row_two_above [DEF_MAX_WIDTH];
    logic [PIX_W-1:0]      win [TAPS][TAPS];
    int unsigned           col;
    int unsigned           row;
    filtered_px_t          expected_q [$];
    int                    errors;
    int                    reported;
    int                    checked;
    int                    frame_ends;

    function void clear();
      width_reg  = 32'(FRAME_WIDTH_RESET);
      height_reg = 32'(FRAME_HEIGHT_RESET);
      foreach (coeff_row[i]) coeff_row[i] = COEFF_ROW_RESET;
      foreach (row_above[i]) begin
        row_above[i]     = '0;
        row_two_above[i] = '0;
      end
      foreach (win[i, j]) win[i][j] = '0;
      col = 0;
      row = 0;
      expected_q.delete();
      errors     = 0;
      reported   = 0;
      checked    = 0;
      frame_ends = 0;
    endfunction

    function int unsigned clamp_dim(int unsigned v, int unsigned lo, int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function int unsigned frame_pixels();
      return clamp_dim(width_reg, MIN_DIM, DEF_MAX_WIDTH) *
             clamp_dim(height_reg, MIN_DIM, MAX_HEIGHT);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_FRAME_WIDTH: begin
          width_reg = 32'(val[FRAME_WIDTH_W-1:0]);
          col = 0;
          row = 0;
        end
        REG_FRAME_HEIGHT: begin
          height_reg = 32'(val[FRAME_HEIGHT_W-1:0]);
          col = 0;
          row = 0;
        end
        REG_COEFF_TOP:    coeff_row[0] = val;
        REG_COEFF_MID:    coeff_row[1] = val;
        REG_COEFF_BOTTOM: coeff_row[2] = val;
        default: ;
      endcase
    endfunction

    // one pixel in raster order; queues a result for interior positions
    function void note_pixel(logic [PIX_W-1:0] px);
      int unsigned                w;
      int unsigned                h;
      int unsigned                c;
      int unsigned                r;
      int                         i;
      int                         j;
      longint                     acc;
      longint                     q;
      logic signed [COEFF_W-1:0] tap;
      filtered_px_t               res;
      w = clamp_dim(width_reg, MIN_DIM, DEF_MAX_WIDTH);
      h = clamp_dim(height_reg, MIN_DIM, MAX_HEIGHT);
      if (col >= w) col = 0;
      if (row >= h) row = 0;
      c = col;
      r = row;
      for (i = 0; i < TAPS; i++) begin
        win[i][0] = win[i][1];
        win[i][1] = win[i][2];
      end
      win[0][2] = row_two_above[c];
      win[1][2] = row_above[c];
      win[2][2] = px;
      row_two_above[c] = row_above[c];
      row_above[c]     = px;
      if (r >= FIRST_INTERIOR && c >= FIRST_INTERIOR) begin
        acc = 0;
        for (i = 0; i < TAPS; i++) begin
          for (j = 0; j < TAPS; j++) begin
            tap = coeff_row[i][j*COEFF_W +: COEFF_W];
            acc += longint'(win[i][j]) * longint'(tap);
          end
        end
        if (acc <= 0) begin
          q = 0;
        end else begin
          q = acc >>> DEF_COEFF_FRAC_BITS;
          if (q > PIX_MAX) q = PIX_MAX;
        end
        res.pix  = q[PIX_W-1:0];
        res.last = (r == h - 1) && (c == w - 1);
        expected_q.push_back(res);
      end
      c++;
      if (c >= w) begin
        c = 0;
        r++;
        if (r >= h) r = 0;
      end
      col = c;
      row = r;
    endfunction

    function void check_result(logic [PIX_W-1:0] pix, logic last);
      filtered_px_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (reported < REPORT_LIMIT) begin
          reported++;
          $display("unexpected result: pix %0d last %0b", pix, last);
        end
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (want.last) frame_ends++;
      if (want.pix !== pix || want.last !== last) begin
        errors++;
        if (reported < REPORT_LIMIT) begin
          reported++;
          $display("result %0d mismatch: expected pix %0d last %0b, got pix %0d last %0b",
                   checked, want.pix, want.last, pix, last);
        end
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [PIX_W-1:0]      s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [PIX_W-1:0]      m_tdata;
  logic                  m_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  filter_scoreboard sb = new;
  cfg_write_t       cfg_batch [$];
  int unsigned      src_idle_pct = 8;
  int unsigned      sink_idle_pct = 88;
  int unsigned      cycle_count = 0;
  int unsigned      pixels_sent = 0;
  int unsigned      random_items = 0;
  int unsigned      reg_writes = 0;

  conv3x3_image_filter #(
    .MAX_WIDTH       (DEF_MAX_WIDTH),
    .COEFF_FRAC_BITS (DEF_COEFF_FRAC_BITS)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99, 0) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
  end

  function automatic void set_idling(int unsigned src_pct, int unsigned sink_pct);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
  endfunction

  function automatic void queue_dim(cfg_reg_t idx, int unsigned v);
    cfg_write_t wr;
    wr.idx = idx;
    wr.val = $urandom_range(1, 0) ? CFG_DATA_W'({$urandom, $urandom}) : '0;
    if (idx == REG_FRAME_WIDTH) wr.val[FRAME_WIDTH_W-1:0] = v[FRAME_WIDTH_W-1:0];
    else wr.val[FRAME_HEIGHT_W-1:0] = v[FRAME_HEIGHT_W-1:0];
    cfg_batch.push_back(wr);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] kernel_row(kernel_kind_t kind);
    logic [CFG_DATA_W-1:0] val;
    int                    t;
    int                    j;
    case (kind)
      KERNEL_BOX:     val = COEFF_ROW_RESET;
      KERNEL_FULL:    val = CFG_DATA_W'({$urandom, $urandom});
      KERNEL_MAX_POS: val = {TAPS{COEFF_MAX_POS}};
      KERNEL_MAX_NEG: val = {TAPS{COEFF_MAX_NEG}};
      KERNEL_ZERO:    val = '0;
      default: begin
        for (j = 0; j < TAPS; j++) begin
          t = int'($urandom_range(2048, 0)) - 1024;
          val[j*COEFF_W +: COEFF_W] = t[COEFF_W-1:0];
        end
      end
    endcase
    return val;
  endfunction

  function automatic void queue_kernel(int row_idx, kernel_kind_t kind);
    cfg_write_t wr;
    wr.idx = cfg_idx_t'(int'(REG_COEFF_TOP) + row_idx);
    wr.val = kernel_row(kind);
    cfg_batch.push_back(wr);
  endfunction

  function automatic kernel_kind_t pick_kernel();
    int unsigned p;
    p = $urandom_range(99, 0);
    if (p < 50) return KERNEL_SMALL;
    if (p < 65) return KERNEL_FULL;
    if (p < 75) return KERNEL_BOX;
    if (p < 83) return KERNEL_MAX_POS;
    if (p < 91) return KERNEL_MAX_NEG;
    return KERNEL_ZERO;
  endfunction

  function automatic void queue_unmapped();
    cfg_write_t wr;
    wr.idx = cfg_idx_t'($urandom_range(REG_UNMAPPED_LAST, REG_UNMAPPED_FIRST));
    wr.val = CFG_DATA_W'({$urandom, $urandom});
    cfg_batch.push_back(wr);
  endfunction

  task automatic flush_cfg();
    cfg_write_t wr;
    if (cfg_batch.size() == 0) return;
    while (cfg_batch.size() != 0) begin
      wr = cfg_batch.pop_front();
      cfg_valid <= 1'b1;
      cfg_index <= wr.idx;
      cfg_data  <= wr.val;
      do @(posedge clk); while (!cfg_ready);
      sb.write_reg(wr.idx, wr.val);
      reg_writes++;
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_pixel(logic [PIX_W-1:0] px);
    while ($urandom_range(99, 0) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= px;
    do @(posedge clk); while (!s_tready);
    sb.note_pixel(px);
    pixels_sent++;
  endtask

  task automatic wait_results();
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // stream stopped; let the pipeline empty before touching registers
  task automatic idle_block();
    s_tvalid <= 1'b0;
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_random(int unsigned count, bit extremes_only);
    int unsigned n;
    for (n = 0; n < count; n++) begin
      if (extremes_only) send_pixel($urandom_range(1, 0) ? PIX_W'(PIX_MAX) : '0);
      else send_pixel(PIX_W'($urandom_range(PIX_MAX, 0)));
    end
  endtask

  task automatic random_phase();
    int unsigned wv;
    int unsigned hv;
    int unsigned p;
    int unsigned frame;
    int unsigned total;
    int          hold_at;
    int          n;
    int          i;
    bit          extremes_only;
    p = $urandom_range(99, 0);
    if (p < 70) begin
      p  = $urandom_range(99, 0);
      wv = (p < 80) ? $urandom_range(10, 3) : (p < 90) ? $urandom_range(2, 0)
                                                     : $urandom_range(24, 11);
      p  = $urandom_range(99, 0);
      hv = (p < 80) ? $urandom_range(6, 3) : (p < 90) ? $urandom_range(2, 0)
                                                    : $urandom_range(10, 7);
      p  = $urandom_range(99, 0);
      if (p >= 15) queue_dim(REG_FRAME_WIDTH, wv);
      if (p < 15 || p >= 30) queue_dim(REG_FRAME_HEIGHT, hv);
    end
    for (i = 0; i < TAPS; i++) begin
      if ($urandom_range(99, 0) < 40) queue_kernel(i, pick_kernel());
    end
    if ($urandom_range(99, 0) < 15) queue_unmapped();
    flush_cfg();

    frame = sb.frame_pixels();
    total = $urandom_range(2, 1) * frame;
    if ($urandom_range(99, 0) < 30) total += $urandom_range(frame - 1, 1);
    extremes_only = ($urandom_range(99, 0) < 20);
    hold_at = ($urandom_range(3, 0) == 0) ? int'($urandom_range(total - 1, 1)) : -1;
    for (n = 0; n < int'(total); n++) begin
      if (n == hold_at) begin
        s_tvalid <= 1'b0;
        wait_results();
      end
      if (extremes_only) send_pixel($urandom_range(1, 0) ? PIX_W'(PIX_MAX) : '0);
      else send_pixel(PIX_W'($urandom_range(PIX_MAX, 0)));
    end
    random_items += total;
    idle_block();
  endtask

  initial begin
    int i;
    sb.clear();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    set_idling(8, 88);

    // smallest frame with box kernel, center window is the whole frame
    queue_dim(REG_FRAME_WIDTH, MIN_DIM);
    queue_dim(REG_FRAME_HEIGHT, MIN_DIM);
    flush_cfg();
    for (i = 0; i < MIN_DIM * MIN_DIM; i++) send_pixel(i < 4 ? '0 : PIX_W'(PIX_MAX));
    idle_block();

    // largest positive taps saturate high, unknown index ignored
    for (i = 0; i < TAPS; i++) queue_kernel(i, KERNEL_MAX_POS);
    queue_unmapped();
    flush_cfg();
    for (i = 0; i < MIN_DIM * MIN_DIM; i++) send_pixel(PIX_W'(PIX_MAX));
    idle_block();

    // most negative taps give a negative sum, clipped to zero
    for (i = 0; i < TAPS; i++) queue_kernel(i, KERNEL_MAX_NEG);
    flush_cfg();
    for (i = 0; i < MIN_DIM * MIN_DIM; i++) send_pixel(PIX_W'($urandom_range(PIX_MAX, 1)));
    idle_block();

    while (random_items < RANDOM_ITEMS) begin
      if (random_items < RANDOM_ITEMS / 3) set_idling(8, 88);
      else if (random_items < 2 * RANDOM_ITEMS / 3) set_idling(88, 8);
      else set_idling(0, 0);
      random_phase();
    end

    // narrowest row and tallest frame, part of a frame only
    set_idling(0, 0);
    queue_dim(REG_FRAME_WIDTH, 0);
    queue_dim(REG_FRAME_HEIGHT, (1 << FRAME_HEIGHT_W) - 1);
    for (i = 0; i < TAPS; i++) queue_kernel(i, pick_kernel());
    flush_cfg();
    send_random(50 * MIN_DIM + 1, 1'b0);
    idle_block();

    if (sb.pending() != 0) begin
      $display("%0d expected results never arrived", sb.pending());
      sb.errors += sb.pending();
    end
    $display("run covered %0d pixels in, %0d filtered pixels checked, %0d frame ends",
             pixels_sent, sb.checked, sb.frame_ends);
    $display("%0d register writes: small and clamped frames, mixed kernels",
             reg_writes);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/c3f_pkg.sv
hdl/c3f_ram.sv
hdl/c3f_cell.sv
hdl/conv3x3_image_filter.sv
tb/sv/tb_conv3x3_image_filter.sv
